FILE: src/ppp_pkg.sv
// Package: widths, types and register indexes for the predicated pivot partition unit.
`default_nettype none
package ppp_pkg;

    localparam int LANES       = 4;
    localparam int INDEX_BITS  = 20;
    localparam int CURSOR_BITS = INDEX_BITS + 1;
    localparam int VALUE_BITS  = 32;
    localparam int CNT_BITS    = $clog2(LANES + 1);
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 32;

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [INDEX_BITS-1:0]        index_t;
    typedef logic [CURSOR_BITS-1:0]       cursor_t;
    typedef logic [CNT_BITS-1:0]          lane_cnt_t;
    typedef logic [LANES-1:0]             lane_mask_t;
    typedef logic [CFG_IDX_BITS-1:0]      cfg_idx_t;
    typedef logic [CFG_DATA_BITS-1:0]     cfg_data_t;

    localparam cfg_idx_t REG_PIVOT       = CFG_IDX_BITS'(0);
    localparam cfg_idx_t REG_VALUE_COUNT = CFG_IDX_BITS'(1);

endpackage
`default_nettype wire

FILE: src/predicated_pivot_partition_unit.sv
// Top level: branch-free partition of four-lane column items around a pivot.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------------
//  in      | input     | in_valid / in_stall   | first, last, value0..value3
//  out     | output    | out_valid / out_stall | dest0..dest3, high_side, done_res, split_point
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One item per cycle unless stalled; items pass the input register, then the result register.
//  The cursor update sits in the compare and prefix-count logic between the
//  input register and the result register.
//  Reset clears the cursors, the registers pivot and value_count, and both valid flags.
//  An output stall holds the result register; the input register still takes one more item.
`default_nettype none
module predicated_pivot_partition_unit
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   first,
    input  wire logic                   last,
    input  wire ppp_pkg::value_t        value0,
    input  wire ppp_pkg::value_t        value1,
    input  wire ppp_pkg::value_t        value2,
    input  wire ppp_pkg::value_t        value3,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output ppp_pkg::index_t             dest0,
    output ppp_pkg::index_t             dest1,
    output ppp_pkg::index_t             dest2,
    output ppp_pkg::index_t             dest3,
    output ppp_pkg::lane_mask_t         high_side,
    output logic                        done_res,
    output ppp_pkg::cursor_t            split_point,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire ppp_pkg::cfg_idx_t      cfg_index,
    input  wire ppp_pkg::cfg_data_t     cfg_data
);
    import ppp_pkg::*;

    value_t     pivot_reg;
    cursor_t    value_count_reg;
    cursor_t    low_cursor_reg;
    cursor_t    high_cursor_reg;
    cursor_t    low_cursor_next;
    cursor_t    high_cursor_next;

    logic       s1_valid_reg;
    logic       s1_first_reg;
    logic       s1_last_reg;
    value_t     s1_value_reg [LANES];
    logic       s1_advance;

    logic       out_valid_reg;
    index_t     dest_reg [LANES];
    index_t     dest_next [LANES];
    lane_mask_t side_reg;
    lane_mask_t side_next;
    logic       done_reg;
    cursor_t    split_reg;
    cursor_t    split_next;

    logic       in_xfer;
    logic       out_free;

    assign cfg_ready = 1'b1;

    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_stall   = s1_valid_reg && !out_free;
    assign in_xfer    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pivot_reg       <= '0;
            value_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PIVOT:       pivot_reg       <= cfg_data;
                REG_VALUE_COUNT: value_count_reg <= cfg_data[CURSOR_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_first_reg    <= first;
            s1_last_reg     <= last;
            s1_value_reg[0] <= value0;
            s1_value_reg[1] <= value1;
            s1_value_reg[2] <= value2;
            s1_value_reg[3] <= value3;
        end
    end

    // Compare each lane, count earlier lanes per side, step the cursors
    always_comb
    begin
        cursor_t   low_base;
        cursor_t   high_base;
        lane_cnt_t lo_cnt;
        lane_cnt_t hi_cnt;
        low_base  = s1_first_reg ? '0 : low_cursor_reg;
        high_base = s1_first_reg ? value_count_reg - CURSOR_BITS'(1) : high_cursor_reg;
        lo_cnt    = '0;
        hi_cnt    = '0;
        side_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (s1_value_reg[i] >= pivot_reg)
            begin
                dest_next[i] = INDEX_BITS'(high_base - CURSOR_BITS'(hi_cnt));
                side_next[i] = 1'b1;
                hi_cnt       = hi_cnt + CNT_BITS'(1);
            end
            else
            begin
                dest_next[i] = INDEX_BITS'(low_base + CURSOR_BITS'(lo_cnt));
                lo_cnt       = lo_cnt + CNT_BITS'(1);
            end
        end
        low_cursor_next  = low_base + CURSOR_BITS'(lo_cnt);
        high_cursor_next = high_base - CURSOR_BITS'(hi_cnt);
        split_next       = s1_last_reg ? low_cursor_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_cursor_reg  <= '0;
            high_cursor_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                low_cursor_reg  <= low_cursor_next;
                high_cursor_reg <= high_cursor_next;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_advance;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                dest_reg[i] <= dest_next[i];
            end
            side_reg  <= side_next;
            done_reg  <= s1_last_reg;
            split_reg <= split_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign dest0       = dest_reg[0];
    assign dest1       = dest_reg[1];
    assign dest2       = dest_reg[2];
    assign dest3       = dest_reg[3];
    assign high_side   = side_reg;
    assign done_res    = done_reg;
    assign split_point = split_reg;

endmodule
`default_nettype wire
